// File: design/ncd_pkg.sv
// ----------------------------------------------------------------------------
// ncd_pkg
// shared types, codes and constants of the neighbor contrast detector
// ----------------------------------------------------------------------------
`default_nettype none

package ncd_pkg;

  localparam int MaxWidth = 2048;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 12;
  localparam int GeomW    = 12;
  localparam int PixW     = 24;
  localparam int ThrW     = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // reciprocal of 100 scaled by 2**23, exact for the 16 bit product range
  localparam int RecipShift = 23;
  localparam logic [16:0] RecipHundred = 17'd83887;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_BELOW = 2'd2,
    DIR_DIAG  = 2'd3
  } dir_t;

  localparam logic [CfgIdxW-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MARKER    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CH_ENABLE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIRECTION = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIDTH     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT    = 3'd5;

  localparam logic [PixW-1:0]  MarkerReset = 24'hFFFFFF;
  localparam logic [2:0]       ChEnReset   = 3'b111;
  localparam logic [GeomW-1:0] WidthReset  = 12'd640;
  localparam logic [GeomW-1:0] HeightReset = 12'd480;

  // floor(255 * pct / 100)
  function automatic logic [ThrW-1:0] thr_from_pct(input logic [7:0] pct);
    logic [15:0] scaled;
    logic [32:0] prod;
    scaled = {pct, 8'h00} - {8'h00, pct};
    prod   = 33'(scaled) * 33'(RecipHundred);
    return prod[RecipShift +: ThrW];
  endfunction

endpackage

`default_nettype wire

// File: design/neighbor_contrast_detect.sv
// ----------------------------------------------------------------------------
// neighbor_contrast_detect
// compares each rgb pixel with its right, lower or lower-right neighbor
// ----------------------------------------------------------------------------
// pixels enter on the s_axis channel in raster order, packed blue, green, red
// from bit 0. results leave on the m_axis channel: marker color per channel
// where the contrast exceeds the threshold, plus coordinates of the compared
// pixel, frame-accumulated exceed flags on tuser and tlast on the frame's
// last pixel. border pixels without a neighbor produce no result.
// registers are written through the cfg channel (always ready); the user must
// write them only while idle, the block leaves this unchecked. throughput is
// one pixel per clock unless stalled; the previous row sits in a single-port
// line memory (2048 x 24) read and written once per accepted pixel, with the
// read returning the old entry, so consecutive pixels never collide. a stalled
// receiver holds the output register and back pressure reaches s_axis_tready
// once the middle stage is also occupied.
// reset clears counters, stored neighbors, flags and restores register
// defaults; line memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_contrast_detect (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [23:0]                  s_axis_tdata,   // pixel_blue, pixel_green, pixel_red
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [47:0]                  m_axis_tdata,   // out_blue, out_green, out_red,
                                                            // result_row, result_column, pad
  output      logic [2:0]                   m_axis_tuser,   // diff_flags
  output      logic                         m_axis_tlast,   // last_of_frame
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [ncd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ncd_pkg::CfgDataW-1:0] cfg_data
);
  import ncd_pkg::*;

  // configuration
  logic [ThrW-1:0]  thr;
  logic [PixW-1:0]  marker;
  logic [2:0]       ch_en;
  dir_t             dir;
  logic [GeomW-1:0] fw;
  logic [GeomW-1:0] fh;

  // stage 0 state
  logic [ColW-1:0]  col;
  logic [RowW-1:0]  row;
  logic [PixW-1:0]  left_pixel;
  logic [PixW-1:0]  line_mem [MaxWidth];
  logic [PixW-1:0]  rd_data;

  // stage 1
  logic             s1_valid;
  logic             s1_have;
  logic             s1_first;
  logic             s1_last;
  dir_t             s1_dir;
  logic [PixW-1:0]  s1_cur;
  logic [PixW-1:0]  s1_left;
  logic [RowW-1:0]  s1_row;
  logic [ColW-1:0]  s1_col;
  logic [PixW-1:0]  ul_pixel;
  logic [2:0]       acc;

  // output register
  logic             m_valid;
  logic [PixW-1:0]  m_color;
  logic [RowW-1:0]  m_row;
  logic [ColW-1:0]  m_col;
  logic [2:0]       m_flags;
  logic             m_last;

  logic             accept;
  logic             advance;
  logic [GeomW-1:0] weff;
  logic [GeomW-1:0] heff;
  logic             row_end;
  logic             frame_end;
  logic             have;
  logic [RowW-1:0]  rrow;
  logic [ColW-1:0]  rcol;
  logic [ColW-1:0]  col_next;
  logic [RowW-1:0]  row_next;
  logic [PixW-1:0]  ref_pixel;
  logic [PixW-1:0]  color;
  logic [2:0]       flags;
  logic [2:0]       acc_base;
  logic [7:0]       ca;
  logic [7:0]       cb;
  logic [7:0]       cd;

  assign cfg_ready     = 1'b1;
  assign advance       = !m_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= '0;
      marker <= MarkerReset;
      ch_en  <= ChEnReset;
      dir    <= DIR_RIGHT;
      fw     <= WidthReset;
      fh     <= HeightReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOLERANCE: thr    <= thr_from_pct(cfg_data[7:0]);
        REG_MARKER:    marker <= cfg_data[PixW-1:0];
        REG_CH_ENABLE: ch_en  <= cfg_data[2:0];
        REG_DIRECTION: dir    <= dir_t'(cfg_data[1:0]);
        REG_WIDTH:     fw     <= cfg_data[GeomW-1:0];
        REG_HEIGHT:    fh     <= cfg_data[GeomW-1:0];
        default: begin
        end
      endcase
    end
  end

  // geometry and neighbor selection
  always_comb begin
    priority if (fw == '0) begin
      weff = GeomW'(1);
    end else if (fw > GeomW'(MaxWidth)) begin
      weff = GeomW'(MaxWidth);
    end else begin
      weff = fw;
    end
    heff      = (fh == '0) ? GeomW'(1) : fh;
    row_end   = ((GeomW+1)'(col) + (GeomW+1)'(1)) >= (GeomW+1)'(weff);
    frame_end = row_end && (((RowW+1)'(row) + (RowW+1)'(1)) >= (RowW+1)'(heff));
    if (row_end) begin
      col_next = '0;
      row_next = frame_end ? '0 : row + RowW'(1);
    end else begin
      col_next = col + ColW'(1);
      row_next = row;
    end
    have = 1'b0;
    rrow = row;
    rcol = col;
    unique case (dir)
      DIR_RIGHT: begin
        have = (col != '0);
        rcol = col - ColW'(1);
      end
      DIR_BELOW: begin
        have = (row != '0);
        rrow = row - RowW'(1);
      end
      DIR_DIAG: begin
        have = (col != '0) && (row != '0);
        rrow = row - RowW'(1);
        rcol = col - ColW'(1);
      end
      DIR_NONE: begin
        have = 1'b0;
      end
    endcase
  end

  // line memory, read returns the previous row's entry
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data       <= line_mem[col];
      line_mem[col] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      left_pixel <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        col        <= col_next;
        row        <= row_next;
        left_pixel <= s_axis_tdata;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_have  <= have;
      s1_first <= (col == '0) && (row == '0);
      s1_last  <= frame_end;
      s1_dir   <= dir;
      s1_cur   <= s_axis_tdata;
      s1_left  <= left_pixel;
      s1_row   <= rrow;
      s1_col   <= rcol;
    end
  end

  // compare stage
  always_comb begin
    unique case (s1_dir)
      DIR_RIGHT: ref_pixel = s1_left;
      DIR_BELOW: ref_pixel = rd_data;
      DIR_DIAG:  ref_pixel = ul_pixel;
      DIR_NONE:  ref_pixel = s1_left;
    endcase
    color = '0;
    flags = '0;
    for (int k = 0; k < 3; k++) begin
      ca = ref_pixel[8*k +: 8];
      cb = s1_cur[8*k +: 8];
      cd = (ca > cb) ? (ca - cb) : (cb - ca);
      if (ch_en[k] && ({2'b00, cd} > thr)) begin
        flags[k]       = 1'b1;
        color[8*k +: 8] = marker[8*k +: 8];
      end
    end
    acc_base = s1_first ? 3'b000 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ul_pixel <= '0;
      acc      <= '0;
      m_valid  <= 1'b0;
    end else if (advance) begin
      m_valid <= s1_valid && s1_have;
      if (s1_valid) begin
        ul_pixel <= rd_data;
        acc      <= s1_have ? (acc_base | flags) : acc_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_color <= color;
      m_row   <= s1_row;
      m_col   <= s1_col;
      m_flags <= acc_base | flags;
      m_last  <= s1_last;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {1'b0, m_col, m_row, m_color};
  assign m_axis_tuser  = m_flags;
  assign m_axis_tlast  = m_last;

  // memory data must stay aligned with the held middle stage
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s_axis_tready |=> $stable(rd_data))
    else $error("line memory data changed under a stalled pixel");

  // end of a row restarts the column count
  assert property (@(posedge clk) disable iff (rst)
    accept && row_end |=> col == '0)
    else $error("column count did not wrap at row end");

  // no neighbor direction never yields a compare
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_dir == DIR_NONE) |-> !s1_have)
    else $error("compare scheduled with no neighbor direction");

  // a blue marker on the output implies its accumulated blue flag
  assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_color[7:0] != 8'h00) |-> m_flags[0])
    else $error("blue marker without blue flag");

endmodule

`default_nettype wire

// File: tb/tb_neighbor_contrast_detect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neighbor_contrast_detect
// self-checking bench for the neighbor contrast detector
// ----------------------------------------------------------------------------
// streams hand-picked and random rgb pixels in raster order through many
// register setups: every neighbor direction, tolerance and channel enable
// extremes, zero, single and saturated frame sizes, and a narrowing of the
// frame while it is being streamed. a scoreboard class mirrors the
// registers, the line store and the counters, predicts each edge result and
// compares all fields of every result that leaves the block. both stream
// sides idle at random, the receiver stalls for a long stretch once, and
// the sender waits for all results to drain between register setups.
// ----------------------------------------------------------------------------

module tb_neighbor_contrast_detect;
  import ncd_pkg::*;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] row;
    logic [10:0] column;
    logic [2:0]  flags;
    logic        last;
  } edge_result_t;

  class edge_scoreboard;
    logic [7:0]   tol_pct;
    logic [23:0]  marker;
    logic [2:0]   ch_en;
    dir_t         dir;
    logic [11:0]  width_cfg;
    logic [11:0]  height_cfg;
    logic [23:0]  prev_row [MaxWidth];
    logic [23:0]  left_px;
    logic [23:0]  upper_left_px;
    int           col_cnt;
    int           row_cnt;
    logic [2:0]   frame_flags;
    edge_result_t pending_edges [$];
    int           mismatches;
    int           checked;
    int           setups;

    function new();
      tol_pct       = '0;
      marker        = MarkerReset;
      ch_en         = ChEnReset;
      dir           = DIR_RIGHT;
      width_cfg     = WidthReset;
      height_cfg    = HeightReset;
      left_px       = '0;
      upper_left_px = '0;
      col_cnt       = 0;
      row_cnt       = 0;
      frame_flags   = '0;
      mismatches    = 0;
      checked       = 0;
      setups        = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_TOLERANCE: tol_pct    = val[7:0];
        REG_MARKER:    marker     = val[23:0];
        REG_CH_ENABLE: ch_en      = val[2:0];
        REG_DIRECTION: dir        = dir_t'(val[1:0]);
        REG_WIDTH:     width_cfg  = val[11:0];
        REG_HEIGHT:    height_cfg = val[11:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [23:0] px);
      int           w;
      int           h;
      int           thr;
      int           col;
      int           row;
      int           a;
      int           b;
      int           diff;
      logic [23:0]  above;
      logic [23:0]  nb;
      logic [2:0]   hit;
      bit           have;
      bit           row_end;
      bit           frame_end;
      edge_result_t r;
      w = (width_cfg == 0) ? 1 : int'(width_cfg);
      if (w > MaxWidth) w = MaxWidth;
      h = (height_cfg == 0) ? 1 : int'(height_cfg);
      col = col_cnt;
      row = row_cnt;
      thr = (255 * int'(tol_pct)) / 100;
      if (col == 0 && row == 0) frame_flags = '0;
      above     = prev_row[col];
      row_end   = (col + 1 >= w);
      frame_end = row_end && (row + 1 >= h);
      have      = 1'b0;
      nb        = '0;
      r         = '0;
      case (dir)
        DIR_RIGHT: if (col >= 1) begin
          have     = 1'b1;
          nb       = left_px;
          r.row    = 12'(row);
          r.column = 11'(col - 1);
        end
        DIR_BELOW: if (row >= 1) begin
          have     = 1'b1;
          nb       = above;
          r.row    = 12'(row - 1);
          r.column = 11'(col);
        end
        DIR_DIAG: if (row >= 1 && col >= 1) begin
          have     = 1'b1;
          nb       = upper_left_px;
          r.row    = 12'(row - 1);
          r.column = 11'(col - 1);
        end
        default: ;
      endcase
      if (have) begin
        hit = '0;
        for (int k = 0; k < 3; k++) begin
          a    = int'(nb[8*k +: 8]);
          b    = int'(px[8*k +: 8]);
          diff = (a > b) ? a - b : b - a;
          if (ch_en[k] && diff > thr) hit[k] = 1'b1;
        end
        frame_flags = frame_flags | hit;
        r.blue  = hit[0] ? marker[7:0]   : 8'h00;
        r.green = hit[1] ? marker[15:8]  : 8'h00;
        r.red   = hit[2] ? marker[23:16] : 8'h00;
        r.flags = frame_flags;
        r.last  = frame_end;
        pending_edges.push_back(r);
      end
      upper_left_px = above;
      left_px       = px;
      prev_row[col] = px;
      if (row_end) begin
        col_cnt = 0;
        row_cnt = frame_end ? 0 : ((row + 1) & 12'hFFF);
      end else begin
        col_cnt = col + 1;
      end
    endfunction

    function void check_result(logic [47:0] data, logic [2:0] flags, logic last);
      edge_result_t got;
      edge_result_t want;
      got.blue   = data[7:0];
      got.green  = data[15:8];
      got.red    = data[23:16];
      got.row    = data[35:24];
      got.column = data[46:36];
      got.flags  = flags;
      got.last   = last;
      checked++;
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with none pending: tdata=%h tuser=%b tlast=%b",
                   checked, data, flags, last);
        return;
      end
      want = pending_edges.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: want b=%h g=%h r=%h row=%0d col=%0d flags=%b last=%b",
                   checked, want.blue, want.green, want.red, want.row, want.column,
                   want.flags, want.last);
          $display("  got b=%h g=%h r=%h row=%0d col=%0d flags=%b last=%b",
                   got.blue, got.green, got.red, got.row, got.column, got.flags, got.last);
        end
      end
    endfunction
  endclass

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;   // pixel_blue, pixel_green, pixel_red
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;         // out_blue, out_green, out_red,
                                             // result_row, result_column, pad
  logic [2:0]          m_axis_tuser;         // diff_flags
  logic                m_axis_tlast;         // last_of_frame
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index     = '0;
  logic [CfgDataW-1:0] cfg_data      = '0;

  edge_scoreboard sb;
  int             tx_idle_pct   = 0;
  int             rx_idle_pct   = 0;
  int             hold_left     = 0;
  bit             long_hold_req = 1'b0;
  int             sent          = 0;
  logic [23:0]    last_px       = '0;

  neighbor_contrast_detect dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left     = 120;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_pixel(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  task automatic send_pixel(input logic [23:0] px);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // random channels, half of them close to the previous pixel
  function automatic logic [23:0] next_pixel();
    logic [23:0] px;
    int          c;
    int          d;
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(1) == 1) begin
        c = $urandom_range(255);
      end else begin
        d = $urandom_range(120);
        c = int'(last_px[8*k +: 8]) + d - 60;
        if (c < 0) c = 0;
        if (c > 255) c = 255;
      end
      px[8*k +: 8] = 8'(c);
    end
    last_px = px;
    return px;
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_pixel(next_pixel());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_edges.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_setup(input logic [7:0] tol, input logic [23:0] color,
                               input logic [2:0] en, input dir_t dir,
                               input int w, input int h);
    logic [CfgIdxW-1:0]  idx  [6];
    logic [CfgDataW-1:0] vals [6];
    idx  = '{REG_TOLERANCE, REG_MARKER, REG_CH_ENABLE, REG_DIRECTION, REG_WIDTH, REG_HEIGHT};
    vals = '{CfgDataW'(tol), CfgDataW'(color), CfgDataW'(en), CfgDataW'(dir),
             CfgDataW'(w), CfgDataW'(h)};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    sb.setups++;
  endtask

  task automatic random_frames();
    logic [7:0] tol;
    dir_t       dir;
    int         w;
    int         h;
    int         frames;
    case ($urandom_range(5))
      0:       tol = 8'd0;
      1:       tol = 8'd255;
      default: tol = 8'($urandom_range(100));
    endcase
    dir = ($urandom_range(7) == 0) ? DIR_NONE : dir_t'($urandom_range(1, 3));
    w = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
    h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
    if (w == 0) frames = 60 / (h == 0 ? 1 : h);
    else frames = 60 / (w * (h == 0 ? 1 : h));
    if (frames < 1) frames = 1;
    if (frames > 3) frames = 3;
    program_setup(tol, 24'($urandom), 3'($urandom_range(7)), dir, w, h);
    send_random(frames * (w == 0 ? 1 : w) * (h == 0 ? 1 : h));
  endtask

  initial begin
    int mark;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 61;

    // right neighbor, zero tolerance: full swing and equal pixels
    program_setup(8'd0, 24'hFFFFFF, 3'b111, DIR_RIGHT, 3, 2);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF01);
    send_pixel(24'h00FF01);
    // full tolerance never trips
    program_setup(8'd100, 24'h123456, 3'b111, DIR_BELOW, 2, 2);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    // diagonal right at the threshold, green disabled
    program_setup(8'd39, 24'hA5C35A, 3'b101, DIR_DIAG, 3, 2);
    send_pixel(24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h101010);
    send_pixel(24'h808080);
    send_pixel(24'h646363);
    send_pixel(24'hFF64FF);
    // no direction
    program_setup(8'd0, 24'hFFFFFF, 3'b111, DIR_NONE, 2, 1);
    send_pixel(24'h00FFFF);
    send_pixel(24'hFF0000);
    // zero width and height act as one, max tolerance, no channels
    program_setup(8'd255, 24'h000000, 3'b000, DIR_RIGHT, 0, 0);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    // single column still has a vertical neighbor
    program_setup(8'd10, 24'hFFFFFF, 3'b111, DIR_BELOW, 0, 3);
    send_pixel(24'h000000);
    send_pixel(24'h7F7F7F);
    send_pixel(24'h7F7F7F);
    // single row has none
    program_setup(8'd0, 24'hFFFFFF, 3'b111, DIR_BELOW, 4, 1);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);

    mark = sent;
    while (sent - mark < 150) random_frames();

    tx_idle_pct = 61;
    rx_idle_pct = 8;
    mark = sent;
    while (sent - mark < 150) random_frames();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    mark = sent;
    while (sent - mark < 150) random_frames();

    // long receiver hold-off fills the pipe, then a pause mid-frame
    program_setup(8'd20, 24'hC0FFEE, 3'b111, DIR_RIGHT, 10, 6);
    long_hold_req = 1'b1;
    send_random(30);
    drain();
    send_random(30);

    // frame narrowed while in row 1, column 5: row 1 wraps at once, row 2 ends it
    program_setup(8'd15, 24'h5A5A5A, 3'b111, DIR_BELOW, 8, 4);
    send_random(13);
    program_setup(8'd15, 24'h5A5A5A, 3'b111, DIR_BELOW, 5, 3);
    send_random(6);

    // saturated width and tallest frame, started but not run to their end
    program_setup(8'd50, 24'hFFFFFF, 3'b111, DIR_RIGHT, 4095, 1);
    send_random(64);
    program_setup(8'd20, 24'h00FF00, 3'b111, DIR_BELOW, 1, 4095);
    send_random(64);

    drain();
    $display("%0d pixels over %0d register setups, %0d edge results checked, %0d mismatches",
             sent, sb.setups, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_edges.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", sb.pending_edges.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
